[design/dnm_pkg.sv]
// Shared types for the delimiter nesting matcher: input beat, result beat,
// scope stack record and the sequencer-to-output-stage handshake struct.
// No dependencies.
package dnm_pkg;

	typedef struct packed {
		logic       mode;
		logic [7:0] character;
	} item_t;

	typedef struct packed {
		logic [9:0]  ring_index;
		logic [19:0] start_pos;
		logic [20:0] end_pos;
		logic [2:0]  delim_kind;
		logic [4:0]  nest_depth;
		logic [9:0]  parent_index;
		logic        has_parent;
		logic        is_root;
		logic        was_unclosed;
		logic        last_of_run;
	} rec_t;

	// one entry of the scope stack, already cut to the result field widths
	typedef struct packed {
		logic [9:0]  ring_index;
		logic [19:0] start_pos;
		logic [2:0]  delim_kind;
		logic [4:0]  nest_depth;
		logic [9:0]  parent_index;
		logic        has_parent;
	} scope_rec_t;

	typedef struct packed {
		logic valid;
		rec_t rec;
	} seq_res_t;

endpackage

[design/dnm_stack_ram.sv]
// Stack storage for the delimiter nesting matcher: one write port, one read
// port with registered read data. No dependencies.
module dnm_stack_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[design/dnm_seq.sv]
// Sequencer of the delimiter nesting matcher: byte decode, scope and opener
// stacks, ring and position counters, flush walk. Uses dnm_pkg, dnm_stack_ram.
module dnm_seq import dnm_pkg::*; #(
	parameter int STACK_DEPTH   = 32,
	parameter int RING_CAPACITY = 1024,
	parameter int POSITION_BITS = 20
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  item_t    item,
	output logic     ready,
	input  logic     res_ready,
	output seq_res_t res
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);
	localparam int RB = $clog2(RING_CAPACITY + 1);
	localparam int PW = POSITION_BITS + 1;
	localparam int SW = $bits(scope_rec_t);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	localparam logic [2:0] KIND_BRACE  = 3'd0;
	localparam logic [2:0] KIND_SQUARE = 3'd1;
	localparam logic [2:0] KIND_ANGLE  = 3'd2;
	localparam logic [2:0] KIND_PAREN  = 3'd3;
	localparam logic [2:0] KIND_QUOTE  = 3'd4;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LSQ    = 8'h5B;
	localparam logic [7:0] CH_RSQ    = 8'h5D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	logic [1:0]               state_q, state_d;
	logic [7:0]               char_q;
	logic [POSITION_BITS-1:0] bytepos_q;
	logic                     skip_q;
	logic [PW-1:0]            pos_q;
	logic [CW-1:0]            scope_cnt_q, scope_cnt_d;
	logic [CW-1:0]            op_cnt_q, op_cnt_d;
	logic [RB-1:0]            ring_q, ring_d;

	logic                     is_open, is_closer, is_quote;
	logic [2:0]               kind;
	scope_rec_t               top_rec, new_rec;
	logic [SW-1:0]            s_rdata;
	logic [2:0]               top_kind;
	logic                     s_we, k_we;
	logic [CW-1:0]            scope_m1, op_m1;
	logic                     sc_nz, op_nz, can_open, quote_close;
	logic                     do_push, op_pop, do_close, exec_go;

	always_comb begin
		is_open   = 1'b0;
		is_closer = 1'b0;
		is_quote  = 1'b0;
		kind      = KIND_BRACE;
		case (char_q)
			CH_LBRACE: begin kind = KIND_BRACE;  is_open   = 1'b1; end
			CH_RBRACE: begin kind = KIND_BRACE;  is_closer = 1'b1; end
			CH_LSQ:    begin kind = KIND_SQUARE; is_open   = 1'b1; end
			CH_RSQ:    begin kind = KIND_SQUARE; is_closer = 1'b1; end
			CH_LT:     begin kind = KIND_ANGLE;  is_open   = 1'b1; end
			CH_GT:     begin kind = KIND_ANGLE;  is_closer = 1'b1; end
			CH_LPAR:   begin kind = KIND_PAREN;  is_open   = 1'b1; end
			CH_RPAR:   begin kind = KIND_PAREN;  is_closer = 1'b1; end
			CH_DQUOTE: begin kind = KIND_QUOTE;  is_quote  = 1'b1; end
			default:   kind = KIND_BRACE;
		endcase
	end

	assign top_rec = s_rdata;

	assign sc_nz    = (scope_cnt_q != '0);
	assign op_nz    = (op_cnt_q != '0);
	assign can_open = (ring_q < RB'(RING_CAPACITY)) && (scope_cnt_q < CW'(STACK_DEPTH))
		&& (op_cnt_q < CW'(STACK_DEPTH));
	assign quote_close = is_quote && op_nz && (top_kind == KIND_QUOTE);
	assign do_push  = !skip_q && can_open && (is_open || (is_quote && !quote_close));
	assign op_pop   = !skip_q && ((is_closer && op_nz) || quote_close);
	// a closer pops the scope stack only when it matches the opener-stack top
	assign do_close = !skip_q && sc_nz
		&& ((is_closer && op_nz && (top_kind == kind)) || quote_close);
	assign exec_go  = !do_close || res_ready;

	always_comb begin
		new_rec.ring_index   = 10'(ring_q);
		new_rec.start_pos    = 20'(bytepos_q);
		new_rec.delim_kind   = kind;
		new_rec.nest_depth   = 5'(scope_cnt_q);
		new_rec.has_parent   = sc_nz;
		new_rec.parent_index = sc_nz ? top_rec.ring_index : '0;
	end

	always_comb begin
		state_d     = state_q;
		scope_cnt_d = scope_cnt_q;
		op_cnt_d    = op_cnt_q;
		ring_d      = ring_q;
		s_we        = 1'b0;
		k_we        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					state_d = item.mode ? ST_FLUSH : ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (exec_go) begin
					state_d = ST_IDLE;
					if (do_push) begin
						scope_cnt_d = scope_cnt_q + CW'(1);
						op_cnt_d    = op_cnt_q + CW'(1);
						ring_d      = ring_q + RB'(1);
						s_we        = 1'b1;
						k_we        = 1'b1;
					end
					if (op_pop) begin
						op_cnt_d = op_cnt_q - CW'(1);
					end
					if (do_close) begin
						scope_cnt_d = scope_cnt_q - CW'(1);
					end
				end
			end
			ST_FLUSH: begin
				if (!sc_nz) begin
					state_d  = ST_IDLE;
					op_cnt_d = '0;
					ring_d   = '0;
				end else if (res_ready) begin
					scope_cnt_d = scope_cnt_q - CW'(1);
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// read port always follows the top of the stack as it will be next cycle
	assign scope_m1 = scope_cnt_d - CW'(1);
	assign op_m1    = op_cnt_d - CW'(1);

	dnm_stack_ram #(.DEPTH(STACK_DEPTH), .WIDTH(SW)) u_scope_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (scope_cnt_q[IW-1:0]),
		.wdata (new_rec),
		.raddr (scope_m1[IW-1:0]),
		.rdata (s_rdata)
	);

	dnm_stack_ram #(.DEPTH(STACK_DEPTH), .WIDTH(3)) u_kind_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (op_cnt_q[IW-1:0]),
		.wdata (kind),
		.raddr (op_m1[IW-1:0]),
		.rdata (top_kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scope_cnt_q <= '0;
			op_cnt_q    <= '0;
			ring_q      <= '0;
			pos_q       <= '0;
		end else begin
			state_q     <= state_d;
			scope_cnt_q <= scope_cnt_d;
			op_cnt_q    <= op_cnt_d;
			ring_q      <= ring_d;
			if (take && !item.mode && !pos_q[POSITION_BITS]) begin
				pos_q <= pos_q + PW'(1);
			end else if (state_q == ST_FLUSH && !sc_nz) begin
				pos_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_q    <= item.character;
			bytepos_q <= pos_q[POSITION_BITS-1:0];
			skip_q    <= pos_q[POSITION_BITS];
		end
	end

	assign ready = (state_q == ST_IDLE);

	always_comb begin
		res.valid            = ((state_q == ST_EXEC) && do_close)
			|| ((state_q == ST_FLUSH) && sc_nz);
		res.rec.ring_index   = top_rec.ring_index;
		res.rec.start_pos    = top_rec.start_pos;
		res.rec.delim_kind   = top_rec.delim_kind;
		res.rec.nest_depth   = top_rec.nest_depth;
		res.rec.parent_index = top_rec.parent_index;
		res.rec.has_parent   = top_rec.has_parent;
		res.rec.was_unclosed = (state_q == ST_FLUSH);
		if (state_q == ST_FLUSH) begin
			res.rec.end_pos     = 21'(pos_q);
			res.rec.is_root     = 1'b1;
			res.rec.last_of_run = (scope_cnt_q == CW'(1));
		end else begin
			res.rec.end_pos     = 21'(bytepos_q);
			res.rec.is_root     = (scope_cnt_q == CW'(1));
			res.rec.last_of_run = 1'b1;
		end
	end

endmodule

[design/delimiter_nesting_matcher.sv]
// Delimiter nesting matcher.
// Input channel item/item_valid/item_stall carries one text byte per beat
// (mode 0) or an end-of-text marker (mode 1). Output channel rec/rec_valid/
// rec_stall carries one ring record per beat, held in an output register.
// A text byte is handled in an accept state and then an execute state that
// acts on the stack tops, which come from the registered read port of the
// stack RAMs. A matching closer's record shows on rec_valid the cycle after
// execute. A new byte is taken only after the last one has left execute.
// End of text emits the open rings one record per cycle while the output
// is not stalled, top of stack first, and then clears the counters.
// item_stall is high while a byte or flush is in progress; a stalled output
// register holds its beat and the sequencer waits for it to drain before it
// finishes a byte that closes a ring or emits the next flush record.
// Reset empties both stacks and zeros the ring and position counters; the
// stack RAMs are not cleared and need no clearing pass.
// Depends on dnm_pkg, dnm_seq, dnm_stack_ram.
module delimiter_nesting_matcher import dnm_pkg::*; #(
	parameter int STACK_DEPTH   = 32,
	parameter int RING_CAPACITY = 1024,
	parameter int POSITION_BITS = 20
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  rec_valid,
	input  logic  rec_stall,
	output rec_t  rec
);

	logic     ready;
	logic     take;
	logic     res_ready;
	seq_res_t seq_res;
	logic     rec_valid_q;
	rec_t     rec_q;

	assign item_stall = !ready;
	assign take       = item_valid && ready;
	assign res_ready  = !rec_valid_q || !rec_stall;

	dnm_seq #(
		.STACK_DEPTH   (STACK_DEPTH),
		.RING_CAPACITY (RING_CAPACITY),
		.POSITION_BITS (POSITION_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item),
		.ready     (ready),
		.res_ready (res_ready),
		.res       (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (res_ready) begin
			rec_valid_q <= seq_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && seq_res.valid) begin
			rec_q <= seq_res.rec;
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec       = rec_q;

`ifndef NO_ASSERTIONS
	// an accepted beat makes the block busy in the following cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input accepted again right after a beat");

	// a fresh record only follows a cycle in which the sequencer was busy
	a_rec_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !$past(rec_valid) |-> $past(item_stall))
		else $error("record appeared while sequencer idle");

	// sequencer keeps offering a record until the output register takes it
	a_res_holds: assert property (@(posedge clk) disable iff (!arst_n)
		seq_res.valid && !res_ready |=> seq_res.valid && $stable(seq_res.rec))
		else $error("sequencer record dropped under stall");
`endif

endmodule

[tb/tb_delimiter_nesting_matcher.sv]
// Self-checking testbench for delimiter_nesting_matcher: drives text bytes and
// end-of-text beats and predicts every ring record in a model of its own.
// Depends on dnm_pkg and the delimiter_nesting_matcher RTL only.
`timescale 1ns / 100ps

module tb_delimiter_nesting_matcher;
	import dnm_pkg::*;

	localparam int STACK_DEPTH   = 32;
	localparam int RING_CAPACITY = 1024;
	localparam int POSITION_BITS = 20;
	localparam int TEXT_LIMIT    = 1 << POSITION_BITS;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS   = 200;
	localparam longint TIMEOUT_NS = 64'd1_000_000;

	localparam logic MODE_TEXT = 1'b0;
	localparam logic MODE_END  = 1'b1;

	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_LANGLE  = 8'h3C;
	localparam logic [7:0] CH_RANGLE  = 8'h3E;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_LETTER  = 8'h78;

	typedef enum logic [2:0] {
		K_BRACE  = 3'd0,
		K_SQUARE = 3'd1,
		K_ANGLE  = 3'd2,
		K_PAREN  = 3'd3,
		K_QUOTE  = 3'd4
	} delim_kind_e;

	typedef enum logic [1:0] {
		BYTE_PLAIN,
		BYTE_OPEN,
		BYTE_CLOSE,
		BYTE_QUOTE
	} byte_class_e;

	// one open ring as the tracker keeps it on its scope stack
	typedef struct {
		logic [9:0]  ring;
		logic [19:0] open_at;
		delim_kind_e kind;
		logic [4:0]  depth;
		logic [9:0]  parent;
		logic        has_parent;
	} open_ring_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_stall;
	item_t item = '0;
	logic  rec_valid;
	logic  rec_stall = 1'b0;
	rec_t  rec;

	// tracker state
	open_ring_t  scope_stk [STACK_DEPTH];
	logic [5:0]  scope_cnt;
	delim_kind_e opener_stk [STACK_DEPTH];
	logic [5:0]  opener_cnt;
	logic [10:0] rings_used;
	logic [20:0] text_len;

	rec_t pending_rings [$];
	int unsigned errors = 0;
	int unsigned rings_seen = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;

	delimiter_nesting_matcher #(
		.STACK_DEPTH  (STACK_DEPTH),
		.RING_CAPACITY(RING_CAPACITY),
		.POSITION_BITS(POSITION_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec       (rec)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

	always @(negedge clk) begin
		rec_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rec_valid && !rec_stall)
			check_ring(rec);
	end

	// ---------------------------------------------------------------- tracker

	function automatic byte_class_e classify(input logic [7:0] c, output delim_kind_e k);
		k = K_BRACE;
		case (c)
			CH_LBRACE: return BYTE_OPEN;
			CH_RBRACE: return BYTE_CLOSE;
			CH_LSQUARE: begin
				k = K_SQUARE;
				return BYTE_OPEN;
			end
			CH_RSQUARE: begin
				k = K_SQUARE;
				return BYTE_CLOSE;
			end
			CH_LANGLE: begin
				k = K_ANGLE;
				return BYTE_OPEN;
			end
			CH_RANGLE: begin
				k = K_ANGLE;
				return BYTE_CLOSE;
			end
			CH_LPAREN: begin
				k = K_PAREN;
				return BYTE_OPEN;
			end
			CH_RPAREN: begin
				k = K_PAREN;
				return BYTE_CLOSE;
			end
			CH_QUOTE: begin
				k = K_QUOTE;
				return BYTE_QUOTE;
			end
			default: return BYTE_PLAIN;
		endcase
	endfunction

	function automatic logic [7:0] opener_of(input delim_kind_e k);
		case (k)
			K_BRACE:  return CH_LBRACE;
			K_SQUARE: return CH_LSQUARE;
			K_ANGLE:  return CH_LANGLE;
			K_PAREN:  return CH_LPAREN;
			default:  return CH_QUOTE;
		endcase
	endfunction

	function automatic logic [7:0] closer_of(input delim_kind_e k);
		case (k)
			K_BRACE:  return CH_RBRACE;
			K_SQUARE: return CH_RSQUARE;
			K_ANGLE:  return CH_RANGLE;
			K_PAREN:  return CH_RPAREN;
			default:  return CH_QUOTE;
		endcase
	endfunction

	task automatic clear_tracker();
		scope_cnt = '0;
		opener_cnt = '0;
		rings_used = '0;
		text_len = '0;
	endtask

	task automatic emit_ring(input open_ring_t r, input logic [20:0] closed_at,
			input logic root, input logic unclosed, input logic last);
		rec_t e;
		e.ring_index   = r.ring;
		e.start_pos    = r.open_at;
		e.end_pos      = closed_at;
		e.delim_kind   = r.kind;
		e.nest_depth   = r.depth;
		e.parent_index = r.has_parent ? r.parent : '0;
		e.has_parent   = r.has_parent;
		e.is_root      = root;
		e.was_unclosed = unclosed;
		e.last_of_run  = last;
		pending_rings = {pending_rings, e};
	endtask

	task automatic open_ring(input delim_kind_e k, input logic [19:0] pos);
		open_ring_t r;
		// silently dropped once rings or either stack run out
		if (rings_used >= RING_CAPACITY || scope_cnt >= STACK_DEPTH
				|| opener_cnt >= STACK_DEPTH)
			return;
		r.ring = rings_used[9:0];
		r.open_at = pos;
		r.kind = k;
		r.depth = scope_cnt[4:0];
		r.has_parent = (scope_cnt != 0);
		r.parent = '0;
		if (scope_cnt != 0)
			r.parent = scope_stk[scope_cnt - 1].ring;
		scope_stk[scope_cnt] = r;
		scope_cnt++;
		opener_stk[opener_cnt] = k;
		opener_cnt++;
		rings_used++;
	endtask

	// pops the scope top, which after a mismatch need not be the ring just matched
	task automatic close_ring(input logic [19:0] pos);
		if (scope_cnt == 0)
			return;
		scope_cnt--;
		emit_ring(scope_stk[scope_cnt], {1'b0, pos}, scope_cnt == 0, 1'b0, 1'b1);
	endtask

	task automatic track_delimiters(input item_t it);
		delim_kind_e k;
		byte_class_e cls;
		logic [19:0] pos;
		if (it.mode == MODE_END) begin
			while (scope_cnt != 0) begin
				scope_cnt--;
				emit_ring(scope_stk[scope_cnt], text_len, 1'b1, 1'b1, scope_cnt == 0);
			end
			clear_tracker();
			return;
		end
		if (text_len >= TEXT_LIMIT)
			return;
		pos = text_len[19:0];
		text_len++;
		cls = classify(it.character, k);
		case (cls)
			BYTE_OPEN: open_ring(k, pos);
			BYTE_CLOSE: begin
				if (opener_cnt != 0) begin
					opener_cnt--;
					if (opener_stk[opener_cnt] == k)
						close_ring(pos);
				end
			end
			BYTE_QUOTE: begin
				if (opener_cnt != 0 && opener_stk[opener_cnt - 1] == K_QUOTE) begin
					opener_cnt--;
					close_ring(pos);
				end else begin
					open_ring(K_QUOTE, pos);
				end
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_error(input string msg);
		// quiet after the first couple of hundred, still counted
		if (errors < MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [20:0] got,
			input logic [20:0] want);
		if (got !== want)
			report_error($sformatf("record %0d: %s got %0h want %0h", rings_seen, name,
				got, want));
	endtask

	task automatic check_ring(input rec_t got);
		rec_t want;
		if (pending_rings.size() == 0) begin
			report_error($sformatf("unexpected record for ring %0d", got.ring_index));
			return;
		end
		want = pending_rings.pop_front();
		check_field("ring_index", got.ring_index, want.ring_index);
		check_field("start_pos", got.start_pos, want.start_pos);
		check_field("end_pos", got.end_pos, want.end_pos);
		check_field("delim_kind", got.delim_kind, want.delim_kind);
		check_field("nest_depth", got.nest_depth, want.nest_depth);
		check_field("parent_index", got.parent_index, want.parent_index);
		check_field("has_parent", got.has_parent, want.has_parent);
		check_field("is_root", got.is_root, want.is_root);
		check_field("was_unclosed", got.was_unclosed, want.was_unclosed);
		check_field("last_of_run", got.last_of_run, want.last_of_run);
		rings_seen++;
	endtask

	// ---------------------------------------------------------------- driving

	task automatic send_beat(input item_t it);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
		track_delimiters(it);
	endtask

	task automatic send_char(input logic [7:0] c);
		item_t it;
		it.mode = MODE_TEXT;
		it.character = c;
		send_beat(it);
	endtask

	task automatic send_end(input logic [7:0] junk);
		item_t it;
		it.mode = MODE_END;
		it.character = junk;
		send_beat(it);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_rings.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		// every kind nested, with a quote pair in the middle
		send_char(CH_LBRACE);
		send_char(CH_LSQUARE);
		send_char(CH_LANGLE);
		send_char(CH_LPAREN);
		send_char(CH_QUOTE);
		send_char(CH_LETTER);
		send_char(CH_QUOTE);
		send_char(CH_RPAREN);
		send_char(CH_RANGLE);
		send_char(CH_RSQUARE);
		send_char(CH_RBRACE);
		send_char(CH_RPAREN);	// no opener left
		send_end(8'h00);	// nothing open
		// mismatched closer drops the square opener; the paren then pops the square ring
		send_char(CH_LPAREN);
		send_char(CH_LSQUARE);
		send_char(CH_RPAREN);
		send_char(CH_RPAREN);
		send_char(8'hFF);
		send_char(8'h00);
		send_end(8'hFF);
	endtask

	task automatic test_stack_full();
		// one more opener than the stack holds, then a flush of the full stack
		for (int i = 0; i <= STACK_DEPTH; i++)
			send_char(opener_of(delim_kind_e'(i % 5)));
		send_end(8'($urandom_range(255)));
	endtask

	task automatic test_random_text(input int unsigned n);
		item_t it;
		int unsigned pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			it.mode = MODE_TEXT;
			it.character = 8'($urandom_range(255));
			if (pick < 4) begin
				it.mode = MODE_END;
			end else if (pick < 36) begin
				it.character = opener_of(delim_kind_e'($urandom_range(4)));
			end else if (pick < 66) begin
				// mostly close what is really open
				if (opener_cnt != 0)
					it.character = closer_of(opener_stk[opener_cnt - 1]);
				else
					it.character = closer_of(delim_kind_e'($urandom_range(3)));
			end else if (pick < 74) begin
				it.character = closer_of(delim_kind_e'($urandom_range(3)));
			end
			send_beat(it);
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		clear_tracker();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_pct = 0;
		stall_pct = 0;
		test_directed();
		test_stack_full();
		test_random_text(30);

		idle_pct = 68;
		stall_pct = 0;
		test_random_text(20);
		wait_drained();	// hold the sender until every record is out
		test_random_text(15);

		idle_pct = 0;
		stall_pct = 68;
		test_random_text(30);
		test_stack_full();

		idle_pct = 15;
		stall_pct = 15;
		test_random_text(30);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_rings.size() != 0)
			report_error($sformatf("%0d records never arrived", pending_rings.size()));
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
design/dnm_pkg.sv
design/dnm_stack_ram.sv
design/dnm_seq.sv
design/delimiter_nesting_matcher.sv
tb/tb_delimiter_nesting_matcher.sv
